// ===== hw/rtl/assert_macros.svh =====
// assertion helpers, clocked on clk_i and quiet while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PTF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ptf_pkg.sv =====
`timescale 1ns / 1ps
package ptf_pkg;

  localparam int OFFSET_BITS = 10;
  localparam int NUM_PAGES   = 8;
  localparam int FRAME_BITS  = 8;
  localparam int ADDR_W      = 16;
  localparam int PAGE_W      = $clog2(NUM_PAGES);
  localparam int VPN_W       = ADDR_W - OFFSET_BITS;
  localparam int PA_W        = FRAME_BITS + OFFSET_BITS;
  localparam int DISK_W      = 8;
  localparam int IDX_W       = 3;
  localparam int CFG_W       = 4;

  localparam logic [CFG_W-1:0] PAGES_IN_USE_RESET = CFG_W'(5);

  typedef enum logic [1:0] {
    OP_READ       = 2'd0,
    OP_WRITE      = 2'd1,
    OP_LOAD_ENTRY = 2'd2,
    OP_LOAD_SLOT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_XLATE = 2'd0,
    KIND_FAULT = 2'd1,
    KIND_RANGE = 2'd2,
    KIND_LOAD  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CMD_ACCESS,
    CMD_RANGE,
    CMD_LOAD_ENTRY,
    CMD_LOAD_SLOT
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TRANS
  } back_state_e;

  typedef struct packed {
    op_e                  opcode;
    logic [ADDR_W-1:0]    logical_address;
    logic [IDX_W-1:0]     entry_index;
    logic [FRAME_BITS-1:0] entry_frame;
    logic                 entry_present;
    logic [DISK_W-1:0]    entry_disk_block;
    logic [PAGE_W-1:0]    queued_page;
  } in_item_t;

  typedef struct packed {
    kind_e                 kind;
    logic [PA_W-1:0]       physical_address;
    logic [PAGE_W-1:0]     victim_page;
    logic [FRAME_BITS-1:0] reused_frame;
    logic                  write_back;
    logic [DISK_W-1:0]     write_back_block;
    logic [DISK_W-1:0]     fetch_block;
    logic                  last;
  } out_item_t;

  // classified command passed from front to back
  typedef struct packed {
    cmd_e                  kind;
    logic                  is_write;
    logic [PAGE_W-1:0]     page;
    logic [OFFSET_BITS-1:0] offset;
    logic [IDX_W-1:0]      idx;
    logic [FRAME_BITS-1:0] frame;
    logic                  present;
    logic [DISK_W-1:0]     disk;
    logic [PAGE_W-1:0]     qpage;
  } cmd_t;

endpackage

// ===== hw/rtl/paged_translation_fifo_replace.sv =====
`timescale 1ns / 1ps
// Paged address translation with FIFO replacement. Items enter through a
// two-entry command queue, so the input side keeps accepting, until the
// queue is full, while the back end works and while a result waits in the
// output register. An access to a present page first reads the frame and
// disk block memories into registers and then delivers, and a page fault
// gives a fault transfer followed by the translation transfer. The page
// table length register is written over its own valid/ready port, always
// ready; the user must write it only while the block is idle, which the
// block does not enforce. No clearing pass is needed after reset:
// per-entry valid bits make unwritten table entries read zero.
`include "assert_macros.svh"
module paged_translation_fifo_replace #(
  parameter int RESIDENT_FRAMES = 3
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [ptf_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  ptf_pkg::in_item_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output ptf_pkg::out_item_t        out_data_o
);
  import ptf_pkg::*;

  cmd_t front_cmd;
  cmd_t q_cmd;
  logic q_full, q_valid, q_pop, q_push;

  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  // classify incoming items
  ptf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .item_i     (in_data_i),
    .cmd_o      (front_cmd)
  );

  // decoupling queue
  ptf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (front_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_cmd)
  );

  // table, fifo and result sequencing
  ptf_back #(
    .RESIDENT_FRAMES(RESIDENT_FRAMES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_i      (q_cmd),
    .cmd_pop_o  (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // a fault report never closes an item
  `PTF_ASSERT_NOW(a_fault_not_last, out_valid_o && (out_data_o.kind == KIND_FAULT), !out_data_o.last, "fault result marked last")

  // every other result closes its item
  `PTF_ASSERT_NOW(a_other_last, out_valid_o && (out_data_o.kind != KIND_FAULT), out_data_o.last, "single result not marked last")

  // the translation follows a taken fault report at once
  `PTF_ASSERT_NEXT(a_fault_then_xlate, out_valid_o && !out_stall_i && (out_data_o.kind == KIND_FAULT), out_valid_o && (out_data_o.kind == KIND_XLATE), "translation missing after fault")

  // pops only happen with a command in the queue
  `PTF_ASSERT_NOW(a_pop_nonempty, q_pop, q_valid, "queue popped while empty")

endmodule

// ===== hw/rtl/ptf_front.sv =====
`timescale 1ns / 1ps
module ptf_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ptf_pkg::CFG_W-1:0]  cfg_data_i,
  input  ptf_pkg::in_item_t          item_i,
  output ptf_pkg::cmd_t              cmd_o
);
  import ptf_pkg::*;

  logic [CFG_W-1:0] pages_in_use_q;
  logic [CFG_W-1:0] limit;
  logic [VPN_W-1:0] vpn;
  logic             in_range;

  // page table length register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pages_in_use_q <= PAGES_IN_USE_RESET;
    end else if (cfg_valid_i) begin
      pages_in_use_q <= cfg_data_i;
    end
  end

  // range check against the clamped table length
  assign limit    = (pages_in_use_q > CFG_W'(NUM_PAGES)) ? CFG_W'(NUM_PAGES) : pages_in_use_q;
  assign vpn      = item_i.logical_address[ADDR_W-1:OFFSET_BITS];
  assign in_range = vpn < VPN_W'(limit);

  // classify the item
  always_comb begin
    cmd_o          = '0;
    cmd_o.is_write = (item_i.opcode == OP_WRITE);
    cmd_o.page     = vpn[PAGE_W-1:0];
    cmd_o.offset   = item_i.logical_address[OFFSET_BITS-1:0];
    cmd_o.idx      = item_i.entry_index;
    cmd_o.frame    = item_i.entry_frame;
    cmd_o.present  = item_i.entry_present;
    cmd_o.disk     = item_i.entry_disk_block;
    cmd_o.qpage    = item_i.queued_page;
    case (item_i.opcode)
      OP_READ, OP_WRITE: begin
        cmd_o.kind = in_range ? CMD_ACCESS : CMD_RANGE;
      end
      OP_LOAD_ENTRY: begin
        cmd_o.kind = CMD_LOAD_ENTRY;
      end
      OP_LOAD_SLOT: begin
        cmd_o.kind = CMD_LOAD_SLOT;
      end
      default: begin
        cmd_o.kind = CMD_RANGE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/ptf_queue.sv =====
`timescale 1ns / 1ps
module ptf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ptf_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ptf_pkg::cmd_t data_o
);
  import ptf_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = count_q[1];
  assign valid_o = (count_q != 2'd0);
  assign data_o  = entry_q[rd_ptr_q];

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/ptf_back.sv =====
`timescale 1ns / 1ps
module ptf_back #(
  parameter int RESIDENT_FRAMES = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  ptf_pkg::cmd_t     cmd_i,
  output logic              cmd_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ptf_pkg::out_item_t out_data_o
);
  import ptf_pkg::*;

  localparam int SLOT_W  = (RESIDENT_FRAMES > 1) ? $clog2(RESIDENT_FRAMES) : 1;
  localparam int SLOTX_W = SLOT_W + IDX_W;

  back_state_e state_q, state_d;

  // page table
  logic [NUM_PAGES-1:0]  present_q;
  logic [NUM_PAGES-1:0]  dirty_q;
  logic [FRAME_BITS-1:0] frame_mem [NUM_PAGES];
  logic [NUM_PAGES-1:0]  frame_vld_q;
  logic [DISK_W-1:0]     disk_mem [NUM_PAGES];
  logic [NUM_PAGES-1:0]  disk_vld_q;

  // resident-page fifo
  logic [PAGE_W-1:0] fifo_pages_q [RESIDENT_FRAMES];
  logic [SLOT_W-1:0] head_q;
  logic [SLOTX_W-1:0] slot_ext;

  // registered reads
  logic [FRAME_BITS-1:0] frame_pg_q, frame_v_q;
  logic [DISK_W-1:0]     disk_pg_q, disk_v_q;
  logic [PAGE_W-1:0]     victim_q;
  logic [PAGE_W-1:0]     victim;

  // output register
  out_item_t out_q;
  logic      out_valid_q;
  out_item_t res;
  logic      res_load;
  logic      load_ok;

  // action strobes
  logic do_load_entry, do_load_slot, do_fault, do_set_dirty;

  // frame memory write port
  logic                  frame_we;
  logic [PAGE_W-1:0]     frame_wa;
  logic [FRAME_BITS-1:0] frame_wd;

  assign load_ok  = !out_valid_q || !out_stall_i;
  assign victim   = fifo_pages_q[head_q];
  assign slot_ext = SLOTX_W'(cmd_i.idx);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && (cmd_i.kind == CMD_ACCESS)) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (load_ok) begin
          state_d = present_q[cmd_i.page] ? ST_IDLE : ST_TRANS;
        end
      end
      ST_TRANS: begin
        if (load_ok) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // results and table actions
  always_comb begin
    res           = '0;
    res_load      = 1'b0;
    cmd_pop_o     = 1'b0;
    do_load_entry = 1'b0;
    do_load_slot  = 1'b0;
    do_fault      = 1'b0;
    do_set_dirty  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && load_ok && (cmd_i.kind != CMD_ACCESS)) begin
          res_load      = 1'b1;
          cmd_pop_o     = 1'b1;
          res.last      = 1'b1;
          res.kind      = (cmd_i.kind == CMD_RANGE) ? KIND_RANGE : KIND_LOAD;
          do_load_entry = (cmd_i.kind == CMD_LOAD_ENTRY);
          do_load_slot  = (cmd_i.kind == CMD_LOAD_SLOT);
        end
      end
      ST_EXEC: begin
        if (load_ok) begin
          res_load = 1'b1;
          if (present_q[cmd_i.page]) begin
            cmd_pop_o            = 1'b1;
            do_set_dirty         = cmd_i.is_write;
            res.kind             = KIND_XLATE;
            res.physical_address = {frame_pg_q, cmd_i.offset};
            res.last             = 1'b1;
          end else begin
            do_fault             = 1'b1;
            res.kind             = KIND_FAULT;
            res.victim_page      = victim_q;
            res.reused_frame     = frame_v_q;
            res.write_back       = dirty_q[victim_q];
            res.write_back_block = disk_v_q;
            res.fetch_block      = disk_pg_q;
          end
        end
      end
      ST_TRANS: begin
        if (load_ok) begin
          res_load             = 1'b1;
          cmd_pop_o            = 1'b1;
          do_set_dirty         = cmd_i.is_write;
          res.kind             = KIND_XLATE;
          res.physical_address = {frame_v_q, cmd_i.offset};
          res.last             = 1'b1;
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // present, dirty and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q   <= '0;
      dirty_q     <= '0;
      frame_vld_q <= '0;
      disk_vld_q  <= '0;
    end else begin
      if (do_load_entry) begin
        present_q[cmd_i.idx]   <= cmd_i.present;
        dirty_q[cmd_i.idx]     <= 1'b0;
        frame_vld_q[cmd_i.idx] <= 1'b1;
        disk_vld_q[cmd_i.idx]  <= 1'b1;
      end
      if (do_fault) begin
        present_q[victim_q]     <= 1'b0;
        present_q[cmd_i.page]   <= 1'b1;
        dirty_q[cmd_i.page]     <= 1'b0;
        frame_vld_q[cmd_i.page] <= 1'b1;
      end
      if (do_set_dirty) begin
        dirty_q[cmd_i.page] <= 1'b1;
      end
    end
  end

  // frame and disk block memories
  always_comb begin
    frame_we = do_load_entry || do_fault;
    frame_wa = do_fault ? cmd_i.page : cmd_i.idx;
    frame_wd = do_fault ? frame_v_q : cmd_i.frame;
  end

  always_ff @(posedge clk_i) begin
    if (frame_we) begin
      frame_mem[frame_wa] <= frame_wd;
    end
    if (do_load_entry) begin
      disk_mem[cmd_i.idx] <= cmd_i.disk;
    end
  end

  // operand reads while waiting for a command
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      victim_q   <= victim;
      frame_pg_q <= frame_vld_q[cmd_i.page] ? frame_mem[cmd_i.page] : '0;
      frame_v_q  <= frame_vld_q[victim] ? frame_mem[victim] : '0;
      disk_pg_q  <= disk_vld_q[cmd_i.page] ? disk_mem[cmd_i.page] : '0;
      disk_v_q   <= disk_vld_q[victim] ? disk_mem[victim] : '0;
    end
  end

  // resident fifo and head
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      for (int i = 0; i < RESIDENT_FRAMES; i++) begin
        fifo_pages_q[i] <= '0;
      end
    end else begin
      if (do_load_slot && (slot_ext < SLOTX_W'(RESIDENT_FRAMES))) begin
        fifo_pages_q[slot_ext[SLOT_W-1:0]] <= cmd_i.qpage;
      end
      if (do_fault) begin
        fifo_pages_q[head_q] <= cmd_i.page;
        head_q <= (head_q == SLOT_W'(RESIDENT_FRAMES - 1)) ? '0 : head_q + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
